// ----- rtl/gmtp_pkg.sv -----
// ----------------------------------------------------------------------------
// gmtp_pkg: shared types and constants for the minimum-turn maze search
// Request and result structs, state encoding and fixed field widths.
// ----------------------------------------------------------------------------
package gmtp_pkg;

	// Coordinate math width, enough for 256 rows plus one
	localparam int CRD_W = 9;
	localparam logic [11:0] TURN_MAX = 12'd4095;

	// Register indexes
	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;

	// Request types
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Headings
	localparam logic [1:0] HD_UP    = 2'd0;
	localparam logic [1:0] HD_DOWN  = 2'd1;
	localparam logic [1:0] HD_LEFT  = 2'd2;
	localparam logic [1:0] HD_RIGHT = 2'd3;

	typedef struct packed {
		logic       req_type;
		logic [5:0] row;
		logic [5:0] col;
		logic       blocked;
		logic [5:0] goal_row;
		logic [5:0] goal_col;
	} gmtp_req_t;

	typedef struct packed {
		logic        found;
		logic [11:0] min_turns;
	} gmtp_res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_SEED,
		ST_POP_RD,
		ST_POP_WAIT,
		ST_U_WAIT,
		ST_NB_ADDR,
		ST_NB_CHK,
		ST_GOAL_RD,
		ST_GOAL_CHK,
		ST_DONE
	} gmtp_state_t;

endpackage

// ----- rtl/grid_min_turn_path.sv -----
// ----------------------------------------------------------------------------
// grid_min_turn_path: minimum-turn path search over a loaded maze
// Loads maze cells and answers reach/turn-count queries by 0/1 BFS.
// ----------------------------------------------------------------------------
// A load request is taken while idle and leaves busy low. A query raises busy
// and first sweeps all 4*MAX_ROWS*MAX_COLS turn table entries (16384 at the
// defaults), then seeds four start states, then for each deque pop reads the
// entry and its cost and visits each neighbor through the shared turn
// table port, and finally reads the goal's four headings. Out-of-area and
// start-equals-goal queries skip the search and go straight to done. The result appears on
// result for exactly one cycle with done high; it cannot be held off.
module grid_min_turn_path
	import gmtp_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  gmtp_req_t req,
	input  logic      cfg_valid,
	output logic      cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data,
	output logic      done,
	output gmtp_res_t result
);

	localparam int CELLS   = MAX_ROWS * MAX_COLS;
	localparam int STATES  = 4 * CELLS;
	localparam int DEQ_CAP = 2 * STATES;
	localparam int CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int ST_AW   = $clog2(STATES);
	localparam int DQ_AW   = $clog2(DEQ_CAP);
	localparam int RW      = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW      = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int DQ_W    = RW + CW + 2;
	localparam int COST_W  = $clog2(STATES) + 1;
	localparam int BT_W    = COST_W + 1;

	gmtp_state_t state_q, state_d;

	logic [6:0] rows_q, cols_q;
	logic [CRD_W-1:0] nr_use, nc_use;

	logic [CRD_W-1:0] sr_q, sc_q, gr_q, gc_q;
	logic [CRD_W-1:0] ur_q, uc_q;
	logic [1:0] uh_q, idx_q;
	logic [COST_W-1:0] cost_u_q, best_q;
	logic any_q;
	logic [ST_AW-1:0] clr_q;
	logic [DQ_AW-1:0] head_q;
	logic [DQ_AW:0] count_q;
	logic [CRD_W-1:0] nbr_r_q, nbr_c_q;

	// Memory ports
	logic wall_we, wall_rd;
	logic [CELL_AW-1:0] wall_waddr, wall_raddr;
	logic bt_we;
	logic [ST_AW-1:0] bt_waddr, bt_raddr;
	logic [BT_W-1:0] bt_wdata, bt_rdata;
	logic dq_we;
	logic [DQ_AW-1:0] dq_waddr, dq_raddr;
	logic [DQ_W-1:0] dq_wdata, dq_rdata;

	function automatic logic [CRD_W-1:0] clamp_dim(logic [6:0] v, int maxv);
		logic [CRD_W-1:0] r;
		if (v == 7'd0) r = CRD_W'(1);
		else if (32'(v) > maxv) r = CRD_W'(maxv);
		else r = CRD_W'(v);
		return r;
	endfunction

	function automatic logic [CELL_AW-1:0] cell_of(logic [CRD_W-1:0] r, logic [CRD_W-1:0] c);
		return CELL_AW'(32'(r) * MAX_COLS + 32'(c));
	endfunction

	assign nr_use = clamp_dim(rows_q, MAX_ROWS);
	assign nc_use = clamp_dim(cols_q, MAX_COLS);
	assign cfg_ready = 1'b1;
	assign busy = (state_q != ST_IDLE);

	logic accept, q_load, q_query;
	assign accept  = start && !busy;
	assign q_load  = accept && (req.req_type == REQ_LOAD);
	assign q_query = accept && (req.req_type == REQ_QUERY);

	// Query screening on the raw request
	logic [CRD_W-1:0] in_sr, in_sc, in_gr, in_gc;
	logic q_out, q_same;
	assign in_sr  = CRD_W'(req.row);
	assign in_sc  = CRD_W'(req.col);
	assign in_gr  = CRD_W'(req.goal_row);
	assign in_gc  = CRD_W'(req.goal_col);
	assign q_out  = (in_sr >= nr_use) || (in_sc >= nc_use) ||
	                (in_gr >= nr_use) || (in_gc >= nc_use);
	assign q_same = (in_sr == in_gr) && (in_sc == in_gc);

	// Neighbor of the popped state for heading idx_q
	logic [CRD_W-1:0] nr, nc;
	logic nb_out;
	always_comb begin
		nr = ur_q;
		nc = uc_q;
		nb_out = 1'b0;
		case (idx_q)
			HD_UP: begin
				nb_out = (ur_q == '0);
				nr = ur_q - CRD_W'(1);
			end
			HD_DOWN:  nr = ur_q + CRD_W'(1);
			HD_LEFT: begin
				nb_out = (uc_q == '0);
				nc = uc_q - CRD_W'(1);
			end
			HD_RIGHT: nc = uc_q + CRD_W'(1);
			default: nb_out = 1'b1;
		endcase
		if (nr >= nr_use || nc >= nc_use) nb_out = 1'b1;
	end

	// Shared relax unit: candidate cost and improvement compare
	logic [COST_W-1:0] cand;
	logic improve, wall_hit;
	assign cand     = cost_u_q + COST_W'(idx_q != uh_q);
	assign wall_hit = wall_rd;
	assign improve  = !wall_hit &&
	                  (!bt_rdata[BT_W-1] || (cand < bt_rdata[COST_W-1:0]));

	// Deque pointers
	logic [DQ_AW-1:0] head_dec, head_inc, tail;
	logic [DQ_AW:0] tail_sum;
	logic dq_full;
	assign head_dec = (head_q == '0) ? DQ_AW'(DEQ_CAP - 1) : head_q - DQ_AW'(1);
	assign head_inc = (32'(head_q) == DEQ_CAP - 1) ? '0 : head_q + DQ_AW'(1);
	assign tail_sum = (DQ_AW+1)'(head_q) + count_q;
	assign tail     = (32'(tail_sum) >= DEQ_CAP) ? DQ_AW'(32'(tail_sum) - DEQ_CAP)
	                                             : DQ_AW'(tail_sum);
	assign dq_full  = (32'(count_q) >= DEQ_CAP);

	// Popped entry fields
	logic [CRD_W-1:0] pr, pc;
	logic [1:0] ph;
	assign pr = CRD_W'(dq_rdata[DQ_W-1 -: RW]);
	assign pc = CRD_W'(dq_rdata[CW+1:2]);
	assign ph = dq_rdata[1:0];

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_query) state_d = (q_out || q_same) ? ST_DONE : ST_CLEAR;
			end
			ST_CLEAR:    if (32'(clr_q) == STATES - 1) state_d = ST_SEED;
			ST_SEED:     if (idx_q == HD_RIGHT) state_d = ST_POP_RD;
			ST_POP_RD:   state_d = (count_q == '0) ? ST_GOAL_RD : ST_POP_WAIT;
			ST_POP_WAIT: state_d = ST_U_WAIT;
			ST_U_WAIT:   state_d = ST_NB_ADDR;
			ST_NB_ADDR: begin
				if (!nb_out) state_d = ST_NB_CHK;
				else if (idx_q == HD_RIGHT) state_d = ST_POP_RD;
			end
			ST_NB_CHK:   if (idx_q == HD_RIGHT) state_d = ST_POP_RD;
				else state_d = ST_NB_ADDR;
			ST_GOAL_RD:  state_d = ST_GOAL_CHK;
			ST_GOAL_CHK: state_d = (idx_q == HD_RIGHT) ? ST_DONE : ST_GOAL_RD;
			ST_DONE:     state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Memory port control
	always_comb begin
		wall_we    = q_load && (32'(req.row) < MAX_ROWS) && (32'(req.col) < MAX_COLS);
		wall_waddr = cell_of(CRD_W'(req.row), CRD_W'(req.col));
		wall_raddr = cell_of(nr, nc);
		bt_we    = 1'b0;
		bt_waddr = {cell_of(sr_q, sc_q), idx_q};
		bt_wdata = {1'b1, COST_W'(0)};
		bt_raddr = {cell_of(nr, nc), idx_q};
		dq_we    = 1'b0;
		dq_waddr = tail;
		dq_wdata = {sr_q[RW-1:0], sc_q[CW-1:0], idx_q};
		dq_raddr = head_q;
		case (state_q)
			ST_CLEAR: begin
				bt_we    = 1'b1;
				bt_waddr = clr_q;
				bt_wdata = '0;
			end
			ST_SEED: begin
				bt_we = 1'b1;
				dq_we = 1'b1;
			end
			ST_POP_WAIT: bt_raddr = {cell_of(pr, pc), ph};
			ST_NB_CHK: begin
				bt_waddr = {cell_of(nbr_r_q, nbr_c_q), idx_q};
				bt_wdata = {1'b1, cand};
				bt_we    = improve;
				dq_we    = improve && !dq_full;
				dq_waddr = (idx_q == uh_q) ? head_dec : tail;
				dq_wdata = {nbr_r_q[RW-1:0], nbr_c_q[CW-1:0], idx_q};
			end
			ST_GOAL_RD: bt_raddr = {cell_of(gr_q, gc_q), idx_q};
			default: ;
		endcase
	end

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 7'd64;
			cols_q <= 7'd64;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_ROWS) rows_q <= cfg_data;
			else if (cfg_index == REG_COLS) cols_q <= cfg_data;
		end
	end

	// Advance the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// Advance search counters and deque pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			clr_q   <= '0;
			head_q  <= '0;
			count_q <= '0;
			any_q   <= 1'b0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					clr_q   <= '0;
					idx_q   <= '0;
					head_q  <= '0;
					count_q <= '0;
					any_q   <= q_same && !q_out;
				end
				ST_CLEAR: clr_q <= clr_q + ST_AW'(1);
				ST_SEED: begin
					idx_q   <= idx_q + 2'd1;
					count_q <= count_q + (DQ_AW+1)'(1);
				end
				ST_POP_RD: begin
					idx_q <= '0;
					if (count_q != '0) begin
						head_q  <= head_inc;
						count_q <= count_q - (DQ_AW+1)'(1);
					end
				end
				ST_NB_ADDR: if (nb_out) idx_q <= idx_q + 2'd1;
				ST_NB_CHK: begin
					idx_q <= idx_q + 2'd1;
					if (improve && !dq_full) begin
						count_q <= count_q + (DQ_AW+1)'(1);
						if (idx_q == uh_q) head_q <= head_dec;
					end
				end
				ST_GOAL_CHK: begin
					idx_q <= idx_q + 2'd1;
					if (bt_rdata[BT_W-1] && (!any_q || bt_rdata[COST_W-1:0] < best_q)) begin
						any_q <= 1'b1;
					end
				end
				ST_DONE: done <= 1'b1;
				default: ;
			endcase
		end
	end

	// Hold query payload and search datapath
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				sr_q   <= in_sr;
				sc_q   <= in_sc;
				gr_q   <= in_gr;
				gc_q   <= in_gc;
				best_q <= '0;
			end
			ST_POP_WAIT: begin
				ur_q <= pr;
				uc_q <= pc;
				uh_q <= ph;
			end
			ST_U_WAIT: cost_u_q <= bt_rdata[COST_W-1:0];
			ST_NB_ADDR: begin
				nbr_r_q <= nr;
				nbr_c_q <= nc;
			end
			ST_GOAL_CHK: begin
				if (bt_rdata[BT_W-1] && (!any_q || bt_rdata[COST_W-1:0] < best_q))
					best_q <= bt_rdata[COST_W-1:0];
			end
			default: ;
		endcase
	end

	// Drive the result with saturation
	logic [COST_W+11:0] best_ext;
	assign best_ext = (COST_W+12)'(best_q);
	always_comb begin
		result.found     = any_q;
		result.min_turns = (best_ext > (COST_W+12)'(TURN_MAX)) ? TURN_MAX
		                                                       : best_ext[11:0];
	end

	gmtp_ram #(.W(1), .DEPTH(CELLS), .AW(CELL_AW)) u_wall (
		.clk(clk), .we(wall_we), .waddr(wall_waddr), .wdata(req.blocked),
		.raddr(wall_raddr), .rdata(wall_rd)
	);

	gmtp_ram #(.W(BT_W), .DEPTH(STATES), .AW(ST_AW)) u_turns (
		.clk(clk), .we(bt_we), .waddr(bt_waddr), .wdata(bt_wdata),
		.raddr(bt_raddr), .rdata(bt_rdata)
	);

	gmtp_ram #(.W(DQ_W), .DEPTH(DEQ_CAP), .AW(DQ_AW)) u_deque (
		.clk(clk), .we(dq_we), .waddr(dq_waddr), .wdata(dq_wdata),
		.raddr(dq_raddr), .rdata(dq_rdata)
	);

endmodule

// ----- rtl/gmtp_ram.sv -----
// ----------------------------------------------------------------------------
// gmtp_ram: single-write, single-read memory with registered read data
// Backs the wall map, the turn table and the search deque.
// ----------------------------------------------------------------------------
module gmtp_ram #(
	parameter int W     = 1,
	parameter int DEPTH = 2,
	parameter int AW    = 1
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
